>>> rtl/core/sorted_address_range_table_top_defines.svh
// Assertion macros used by the checker file of the range table.
`ifndef SORTED_ADDRESS_RANGE_TABLE_TOP_DEFINES_SVH
`define SORTED_ADDRESS_RANGE_TABLE_TOP_DEFINES_SVH

// Checked on every clock edge outside of reset.
`define SART_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("range table check failed");

// Checked on every clock edge, reset included.
`define SART_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("range table reset check failed");

`endif

>>> rtl/core/sart_pkg.sv
`default_nettype none

package sart_pkg;

  localparam int MAX_RANGES = 16;
  localparam int CNT_W      = $clog2(MAX_RANGES + 1);
  localparam int ADDR_W     = 32;

  localparam logic [ADDR_W-1:0] LIMIT_RESET = 32'hC000_0000;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_FIND   = 1'b1;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_OVERLAP = 3'd2,
    ST_FULL    = 3'd3,
    ST_MISS    = 3'd4
  } status_t;

  // One stored range.
  typedef struct packed {
    addr_t start_addr;
    addr_t end_addr;
    addr_t flags;
  } entry_t;

  // Controls handed from the top level to each cell.
  typedef struct packed {
    logic shift_en;
    logic prev_keep;
  } cell_ctl_t;

  // Compare results each cell reports back.
  typedef struct packed {
    logic keep;
    logic overlap;
    logic hit;
  } cell_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/sart_if.sv
`default_nettype none

interface sart_in_if;
  logic           valid;
  logic           ready;
  logic           func;
  sart_pkg::addr_t address;
  sart_pkg::addr_t length;
  sart_pkg::addr_t area_flags;

  modport source (output valid, func, address, length, area_flags, input ready);
  modport sink   (input valid, func, address, length, area_flags, output ready);
endinterface

interface sart_out_if;
  logic              valid;
  logic              ready;
  sart_pkg::status_t status;
  sart_pkg::addr_t   hit_start;
  sart_pkg::addr_t   hit_end;
  sart_pkg::addr_t   hit_flags;

  modport source (output valid, status, hit_start, hit_end, hit_flags, input ready);
  modport sink   (input valid, status, hit_start, hit_end, hit_flags, output ready);
endinterface

interface sart_cfg_if;
  logic            valid;
  logic            ready;
  sart_pkg::addr_t data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/sart_cell.sv
`default_nettype none

module sart_cell (
  input  wire logic                 clk,
  input  wire logic                 occ,
  input  wire sart_pkg::addr_t      req_addr,
  input  wire sart_pkg::addr_t      req_end,
  input  wire sart_pkg::entry_t     prev_ent,
  input  wire sart_pkg::entry_t     new_ent,
  input  wire sart_pkg::cell_ctl_t  ctl,
  output sart_pkg::entry_t          ent,
  output sart_pkg::cell_stat_t      stat
);

  sart_pkg::entry_t ent_r;

  assign ent = ent_r;

  // A cell keeps its range when it lies ahead of the new start; the kept
  // cells always form a prefix of the chain since the table is sorted.
  assign stat.keep    = occ && (ent_r.start_addr < req_addr);
  assign stat.overlap = occ && (req_addr < ent_r.end_addr) && (req_end > ent_r.start_addr);
  assign stat.hit     = occ && (req_addr >= ent_r.start_addr) && (req_addr < ent_r.end_addr);

  always_ff @(posedge clk) begin
    if (ctl.shift_en && !stat.keep) begin
      ent_r <= ctl.prev_keep ? new_ent : prev_ent;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/sorted_address_range_table_top.sv
// Sorted table of up to sart_pkg::MAX_RANGES non-overlapping address ranges,
// held in a chain of cells in ascending start order. An insert beat is checked
// against cfg's address limit and against every stored range at once, then the
// cells past the insert point shift one place up together and the new range
// drops into the gap. A find beat returns the range holding the address or a
// miss. Each item passes a compare state and then an update state in the cell
// chain; the result is registered in the update state, which waits while the
// result channel is stalled, and the next input beat can be taken there.
// The address limit may only be written while no item is in flight.
`default_nettype none

module sorted_address_range_table_top (
  input  wire logic   clk,
  input  wire logic   rst_n,
  sart_in_if.sink     in_ch,
  sart_out_if.source  out_ch,
  sart_cfg_if.sink    cfg_ch
);

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_UPD} state_t;

  localparam int N = sart_pkg::MAX_RANGES;

  state_t                     state_r;
  logic [sart_pkg::CNT_W-1:0] count_r;
  sart_pkg::addr_t            limit_r;

  logic                       req_func_r;
  sart_pkg::addr_t            req_addr_r;
  logic [sart_pkg::ADDR_W:0]  req_end_r;
  logic                       req_len_zero_r;
  sart_pkg::addr_t            req_flags_r;

  sart_pkg::status_t          res_status_r;
  sart_pkg::entry_t           res_ent_r;
  logic                       res_ins_r;

  logic                       out_valid_r;
  sart_pkg::status_t          out_status_r;
  sart_pkg::entry_t           out_ent_r;

  sart_pkg::entry_t           ent [N];
  sart_pkg::entry_t           prev_ent [N];
  sart_pkg::cell_stat_t       stat [N];
  sart_pkg::cell_ctl_t        ctl [N];
  sart_pkg::entry_t           new_ent;

  logic                       out_free;
  logic                       shift_en;
  logic                       in_acc;
  logic                       any_ovl;
  logic                       any_hit;
  logic                       invalid;
  logic                       full;
  sart_pkg::entry_t           hit_ent;
  sart_pkg::status_t          cmp_status;

  assign out_free     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE) || ((state_r == S_UPD) && out_free);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign shift_en     = (state_r == S_UPD) && out_free && res_ins_r;
  assign cfg_ch.ready = 1'b1;

  assign new_ent.start_addr = req_addr_r;
  assign new_ent.end_addr   = req_end_r[sart_pkg::ADDR_W-1:0];
  assign new_ent.flags      = req_flags_r;

  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev_ent[i]      = new_ent;
      assign ctl[i].prev_keep = 1'b1;
    end else begin : g_body
      assign prev_ent[i]      = ent[i-1];
      assign ctl[i].prev_keep = stat[i-1].keep;
    end
    assign ctl[i].shift_en = shift_en;

    sart_cell u_cell (
      .clk      (clk),
      .occ      (sart_pkg::CNT_W'(i) < count_r),
      .req_addr (req_addr_r),
      .req_end  (req_end_r[sart_pkg::ADDR_W-1:0]),
      .prev_ent (prev_ent[i]),
      .new_ent  (new_ent),
      .ctl      (ctl[i]),
      .ent      (ent[i]),
      .stat     (stat[i])
    );
  end

  always_comb begin
    any_ovl = 1'b0;
    any_hit = 1'b0;
    hit_ent = '0;
    for (int i = 0; i < N; i++) begin
      any_ovl = any_ovl | stat[i].overlap;
      any_hit = any_hit | stat[i].hit;
      if (stat[i].hit) begin
        hit_ent = hit_ent | ent[i];
      end
    end
  end

  assign invalid = req_len_zero_r || (req_addr_r >= limit_r) ||
                   (req_end_r > {1'b0, limit_r});
  assign full    = (count_r == sart_pkg::CNT_W'(N));

  always_comb begin
    if (req_func_r == sart_pkg::FUNC_FIND) begin
      cmp_status = any_hit ? sart_pkg::ST_OK : sart_pkg::ST_MISS;
    end else if (invalid) begin
      cmp_status = sart_pkg::ST_INVALID;
    end else if (any_ovl) begin
      cmp_status = sart_pkg::ST_OVERLAP;
    end else if (full) begin
      cmp_status = sart_pkg::ST_FULL;
    end else begin
      cmp_status = sart_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      limit_r     <= sart_pkg::LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        limit_r <= cfg_ch.data;
      end
      // In the update state the result register is reloaded instead.
      if (out_valid_r && out_ch.ready && (state_r != S_UPD)) begin
        out_valid_r <= 1'b0;
      end

      if (in_acc) begin
        req_func_r     <= in_ch.func;
        req_addr_r     <= in_ch.address;
        req_end_r      <= {1'b0, in_ch.address} + {1'b0, in_ch.length};
        req_len_zero_r <= (in_ch.length == '0);
        req_flags_r    <= in_ch.area_flags;
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          res_status_r <= cmp_status;
          res_ent_r    <= (req_func_r == sart_pkg::FUNC_FIND) ? hit_ent : '0;
          res_ins_r    <= (req_func_r == sart_pkg::FUNC_INSERT) &&
                          (cmp_status == sart_pkg::ST_OK);
          state_r      <= S_UPD;
        end
        S_UPD: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_ent_r    <= res_ent_r;
            if (res_ins_r) begin
              count_r <= count_r + 1'b1;
            end
            state_r <= in_acc ? S_CMP : S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.hit_start = out_ent_r.start_addr;
  assign out_ch.hit_end   = out_ent_r.end_addr;
  assign out_ch.hit_flags = out_ent_r.flags;

endmodule

`default_nettype wire

>>> rtl/core/sart_checker.sv
`default_nettype none
`include "sorted_address_range_table_top_defines.svh"

module sart_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire sart_pkg::status_t out_status,
  input wire sart_pkg::addr_t   out_hit_start,
  input wire sart_pkg::addr_t   out_hit_end,
  input wire sart_pkg::addr_t   out_hit_flags
);

  // A stalled result beat must hold its status.
  `SART_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_status))

  // Anything but a hit or a successful insert carries zero range fields.
  `SART_ASSERT(a_zero_fields, out_valid && out_status != sart_pkg::ST_OK |-> out_hit_start == '0 && out_hit_end == '0 && out_hit_flags == '0)

  // A returned range is never empty.
  `SART_ASSERT(a_hit_order, out_valid && out_hit_end != '0 |-> out_hit_start < out_hit_end)

  // Work on one item takes the cycle after its accept, so no second accept then.
  `SART_ASSERT(a_no_double, in_valid && in_ready |=> !in_ready)

  // Reset leaves no stale result behind.
  `SART_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid)

endmodule

bind sorted_address_range_table_top sart_checker u_sart_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_status    (out_ch.status),
  .out_hit_start (out_ch.hit_start),
  .out_hit_end   (out_ch.hit_end),
  .out_hit_flags (out_ch.hit_flags)
);

`default_nettype wire
